### rtl/core/tpq_pkg.sv
package tpq_pkg;

   localparam int HANDLE_BITS = 16;
   localparam int COUNT_BITS  = 6;

   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_PEEK    = 2'd2;
   localparam logic [1:0] OP_CLEAR   = 2'd3;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_REJECT = 2'd1;
   localparam logic [1:0] STATUS_EMPTY  = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } tpq_state_type;

   typedef struct packed {
      logic [1:0]             req_type;
      logic                   level;
      logic [HANDLE_BITS-1:0] handle_in;
   } tpq_req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [HANDLE_BITS-1:0] handle_out;
      logic                   from_level;
      logic [COUNT_BITS-1:0]  total_count;
   } tpq_rsp_type;

endpackage

### rtl/core/two_level_priority_queue.sv
// Two-level strict priority queue of packet handles.
// Request channel: a transaction is taken at a rising edge with start high and
// busy low; req_data carries the operation (enqueue, dequeue, peek, clear),
// the level of an enqueued handle and the handle itself.
// Response channel: exactly one response per request, shown on rsp_data for
// one cycle with rsp_valid high. The receiver cannot stall it.
// Order: at the accept edge the request is registered and both level memories
// are read at their head pointers; in the following cycle (busy high) the head
// entries are selected and the tail entry is written, pointers and fill counts
// update and the response is registered onto rsp_data. No new request is taken
// while one executes (busy high), so requests are taken one at a time. A new
// request may be started while the previous response is on rsp_data.
// Reset: pointers and fill counts clear, both levels read as empty. Memory
// contents are not cleared; an entry's value is used only after it was written.
module two_level_priority_queue #(
   parameter int LEVEL_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tpq_pkg::tpq_req_type req_data,
   output logic                 rsp_valid,
   output tpq_pkg::tpq_rsp_type rsp_data
);

   localparam int PTR_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
   localparam int SUM_W = FILL_W + 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LEVEL_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LEVEL_DEPTH);

   logic [tpq_pkg::HANDLE_BITS-1:0] high_mem [LEVEL_DEPTH];
   logic [tpq_pkg::HANDLE_BITS-1:0] low_mem  [LEVEL_DEPTH];

   tpq_pkg::tpq_state_type state_ff, state_in;
   tpq_pkg::tpq_req_type   req_ff;
   tpq_pkg::tpq_rsp_type   rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [tpq_pkg::HANDLE_BITS-1:0] rd_high_ff, rd_low_ff;

   logic [PTR_W-1:0]  high_head_ff, high_head_in, high_tail_ff, high_tail_in;
   logic [PTR_W-1:0]  low_head_ff, low_head_in, low_tail_ff, low_tail_in;
   logic [FILL_W-1:0] high_fill_ff, high_fill_in, low_fill_ff, low_fill_in;
   logic [SUM_W-1:0]  fill_sum;

   logic accept, exec, wr_high, wr_low;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   assign accept = start && !busy;
   assign exec   = (state_ff == tpq_pkg::ST_EXEC);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpq_pkg::ST_IDLE: begin
            if (start) state_in = tpq_pkg::ST_EXEC;
         end
         tpq_pkg::ST_EXEC: state_in = tpq_pkg::ST_IDLE;
         default:          state_in = tpq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      case (state_ff)
         tpq_pkg::ST_IDLE: busy = 1'b0;
         tpq_pkg::ST_EXEC: busy = 1'b1;
         default:          busy = 1'b1;
      endcase
   end

   always_comb begin
      high_head_in = high_head_ff;
      high_tail_in = high_tail_ff;
      high_fill_in = high_fill_ff;
      low_head_in  = low_head_ff;
      low_tail_in  = low_tail_ff;
      low_fill_in  = low_fill_ff;
      wr_high      = 1'b0;
      wr_low       = 1'b0;
      rsp_in       = '0;
      rsp_in.status = tpq_pkg::STATUS_OK;
      if (exec) begin
         case (req_ff.req_type)
            tpq_pkg::OP_ENQUEUE: begin
               if (req_ff.handle_in == '0) begin
                  rsp_in.status = tpq_pkg::STATUS_REJECT;
               end else if (req_ff.level) begin
                  if (high_fill_ff == FILL_FULL) begin
                     rsp_in.status = tpq_pkg::STATUS_REJECT;
                  end else begin
                     wr_high      = 1'b1;
                     high_tail_in = ptr_next(high_tail_ff);
                     high_fill_in = high_fill_ff + FILL_W'(1);
                  end
               end else begin
                  if (low_fill_ff == FILL_FULL) begin
                     rsp_in.status = tpq_pkg::STATUS_REJECT;
                  end else begin
                     wr_low      = 1'b1;
                     low_tail_in = ptr_next(low_tail_ff);
                     low_fill_in = low_fill_ff + FILL_W'(1);
                  end
               end
            end
            tpq_pkg::OP_DEQUEUE, tpq_pkg::OP_PEEK: begin
               if (high_fill_ff != '0) begin
                  rsp_in.handle_out = rd_high_ff;
                  rsp_in.from_level = 1'b1;
                  if (req_ff.req_type == tpq_pkg::OP_DEQUEUE) begin
                     high_head_in = ptr_next(high_head_ff);
                     high_fill_in = high_fill_ff - FILL_W'(1);
                  end
               end else if (low_fill_ff != '0) begin
                  rsp_in.handle_out = rd_low_ff;
                  if (req_ff.req_type == tpq_pkg::OP_DEQUEUE) begin
                     low_head_in = ptr_next(low_head_ff);
                     low_fill_in = low_fill_ff - FILL_W'(1);
                  end
               end else begin
                  rsp_in.status = tpq_pkg::STATUS_EMPTY;
               end
            end
            tpq_pkg::OP_CLEAR: begin
               high_head_in = '0;
               high_tail_in = '0;
               high_fill_in = '0;
               low_head_in  = '0;
               low_tail_in  = '0;
               low_fill_in  = '0;
            end
            default: begin
               rsp_in.status = tpq_pkg::STATUS_OK;
            end
         endcase
      end
      fill_sum = SUM_W'(high_fill_in) + SUM_W'(low_fill_in);
      rsp_in.total_count = tpq_pkg::COUNT_BITS'(fill_sum);
      rsp_valid_in = exec;
   end

   always_ff @(posedge clock) begin
      if (wr_high) high_mem[high_tail_ff] <= req_ff.handle_in;
      if (wr_low)  low_mem[low_tail_ff]   <= req_ff.handle_in;
      if (accept) begin
         rd_high_ff <= high_mem[high_head_ff];
         rd_low_ff  <= low_mem[low_head_ff];
         req_ff     <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         high_head_ff <= '0;
         high_tail_ff <= '0;
         high_fill_ff <= '0;
         low_head_ff  <= '0;
         low_tail_ff  <= '0;
         low_fill_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         high_head_ff <= high_head_in;
         high_tail_ff <= high_tail_in;
         high_fill_ff <= high_fill_in;
         low_head_ff  <= low_head_in;
         low_tail_ff  <= low_tail_in;
         low_fill_ff  <= low_fill_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not enter execution");

   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_valid && !busy))
      else $error("execution cycle did not produce one response");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (high_fill_ff <= FILL_FULL) && (low_fill_ff <= FILL_FULL))
      else $error("level fill count beyond depth");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == tpq_pkg::STATUS_EMPTY) |->
      (rsp_data.total_count == '0 && rsp_data.handle_out == '0))
      else $error("empty response with nonzero count or handle");

endmodule
